// ===== hdl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg
// Types, constants and helpers shared by the line pixel rasterizer modules.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int unsigned GRID_SIZE = 64;
  localparam int unsigned CoordW    = 6;
  localparam int unsigned SideW     = 8;
  // decision variable spans about +/- 4 * (GRID_SIZE - 1)
  localparam int unsigned DecW      = CoordW + 3;

  typedef logic [CoordW-1:0]        coord_t;
  typedef logic signed [SideW-1:0]  side_t;
  typedef logic signed [DecW-1:0]   dec_t;

  localparam coord_t CoordMax = coord_t'(GRID_SIZE - 1);

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   thick;
  } line_in_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    side_t  plus_side_x;
    side_t  plus_side_y;
    side_t  minus_side_x;
    side_t  minus_side_y;
    logic   sides_valid;
    logic   last;
  } pixel_out_t;

  typedef enum logic [0:0] {
    LprIdle = 1'b0,
    LprDraw = 1'b1
  } lpr_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } lpr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic last;
  } lpr_status_t;

  function automatic coord_t coord_clamp(coord_t v);
    coord_t r;
    r = (v > CoordMax) ? CoordMax : v;
    return r;
  endfunction

endpackage

// ===== hdl/lpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpr_ctrl
// Sequencer: takes a segment when idle, then emits one pixel per free slot.
// ----------------------------------------------------------------------------
module lpr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpr_pkg::lpr_status_t status_i,
  output lpr_pkg::lpr_cmd_t    cmd_o
);

  lpr_pkg::lpr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpr_pkg::LprIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lpr_pkg::LprIdle: begin
        if (in_valid_i) begin
          state_d = lpr_pkg::LprDraw;
        end
      end
      lpr_pkg::LprDraw: begin
        if (status_i.slot_free && status_i.last) begin
          state_d = lpr_pkg::LprIdle;
        end
      end
      default: state_d = lpr_pkg::LprIdle;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      lpr_pkg::LprIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      lpr_pkg::LprDraw: begin
        cmd_o.emit = status_i.slot_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/lpr_datapath.sv =====
// ----------------------------------------------------------------------------
// lpr_datapath
// Endpoint ordering, midpoint decision stepping and the output register.
// ----------------------------------------------------------------------------
module lpr_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpr_pkg::line_in_t    in_data_i,
  input  lpr_pkg::lpr_cmd_t    cmd_i,
  output lpr_pkg::lpr_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lpr_pkg::pixel_out_t  out_data_o
);

  localparam int unsigned ExtW = lpr_pkg::DecW - lpr_pkg::CoordW;

  // setup from the input segment
  lpr_pkg::coord_t sx, sy, ex, ey;
  lpr_pkg::coord_t x1, y1, x2, y2;
  lpr_pkg::coord_t ld_dx, ld_dy;
  logic            ld_rising, ld_steep;
  lpr_pkg::dec_t   ldx, ldy, ld_d;

  always_comb begin
    sx = lpr_pkg::coord_clamp(in_data_i.start_x);
    sy = lpr_pkg::coord_clamp(in_data_i.start_y);
    ex = lpr_pkg::coord_clamp(in_data_i.end_x);
    ey = lpr_pkg::coord_clamp(in_data_i.end_y);
    if (sx > ex) begin
      x1 = ex; y1 = ey; x2 = sx; y2 = sy;
    end else begin
      x1 = sx; y1 = sy; x2 = ex; y2 = ey;
    end
    ld_rising = (y1 < y2);
    ld_dx     = x2 - x1;
    ld_dy     = ld_rising ? (y2 - y1) : (y1 - y2);
    ld_steep  = (ld_dy > ld_dx);
    ldx       = lpr_pkg::dec_t'({{ExtW{1'b0}}, ld_dx});
    ldy       = lpr_pkg::dec_t'({{ExtW{1'b0}}, ld_dy});
    case ({ld_rising, ld_steep})
      2'b10:   ld_d = (ldy <<< 1) - ldx;
      2'b11:   ld_d = ldy - (ldx <<< 1);
      2'b00:   ld_d = ldx - (ldy <<< 1);
      default: ld_d = (ldx <<< 1) - ldy;
    endcase
  end

  // walk state
  lpr_pkg::coord_t x_q, y_q, x2_q, y2_q;
  lpr_pkg::dec_t   d_q, dx_q, dy_q;
  logic            rising_q, steep_q, thick_q;

  lpr_pkg::coord_t x_d, y_d;
  lpr_pkg::dec_t   d_d;
  logic            last;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    d_d = d_q;
    case ({rising_q, steep_q})
      2'b10: begin
        if (d_q <= 0) begin
          d_d = d_q + (dy_q <<< 1);
        end else begin
          d_d = d_q + ((dy_q - dx_q) <<< 1);
          y_d = y_q + 1'b1;
        end
        x_d = x_q + 1'b1;
      end
      2'b11: begin
        if (d_q <= 0) begin
          d_d = d_q + ((dy_q - dx_q) <<< 1);
          x_d = x_q + 1'b1;
        end else begin
          d_d = d_q - (dx_q <<< 1);
        end
        y_d = y_q + 1'b1;
      end
      2'b00: begin
        if (d_q > 0) begin
          d_d = d_q - (dy_q <<< 1);
        end else begin
          d_d = d_q + ((dx_q - dy_q) <<< 1);
          y_d = y_q - 1'b1;
        end
        x_d = x_q + 1'b1;
      end
      default: begin
        if (d_q > 0) begin
          d_d = d_q + ((dx_q - dy_q) <<< 1);
          x_d = x_q + 1'b1;
        end else begin
          d_d = d_q + (dx_q <<< 1);
        end
        y_d = y_q - 1'b1;
      end
    endcase
    if (!steep_q) begin
      last = (x_q >= x2_q);
    end else if (rising_q) begin
      last = (y_q >= y2_q);
    end else begin
      last = (y_q <= y2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q      <= x1;
      y_q      <= y1;
      x2_q     <= x2;
      y2_q     <= y2;
      d_q      <= ld_d;
      dx_q     <= ldx;
      dy_q     <= ldy;
      rising_q <= ld_rising;
      steep_q  <= ld_steep;
      thick_q  <= in_data_i.thick;
    end else if (cmd_i.emit) begin
      x_q <= x_d;
      y_q <= y_d;
      d_q <= d_d;
    end
  end

  // pixel and its neighbours
  lpr_pkg::side_t      xs, ys;
  lpr_pkg::pixel_out_t pix;

  always_comb begin
    xs  = lpr_pkg::side_t'({2'b00, x_q});
    ys  = lpr_pkg::side_t'({2'b00, y_q});
    pix = '0;
    pix.pixel_x = x_q;
    pix.pixel_y = y_q;
    pix.last    = last;
    if (thick_q) begin
      pix.sides_valid  = 1'b1;
      pix.plus_side_x  = steep_q ? xs + 8'sd1 : xs;
      pix.plus_side_y  = steep_q ? ys : ys + 8'sd1;
      pix.minus_side_x = steep_q ? xs - 8'sd1 : xs;
      pix.minus_side_y = steep_q ? ys : ys - 8'sd1;
    end
  end

  // output register
  logic                out_valid_q;
  lpr_pkg::pixel_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= pix;
    end
  end

  assign status_o.slot_free = !out_valid_q || !out_stall_i;
  assign status_o.last      = last;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;

endmodule

// ===== hdl/line_pixel_rasterizer.sv =====
// first pixel: the segment is loaded into the walk registers, then its first pixel enters the output register
// throughput: one pixel per cycle while the output is not stalled, after the
//   segment is taken; a segment gives max(|dx|, |dy|) + 1 pixels
// the next segment is taken the cycle after the last pixel enters the output register
// reset: asynchronous active low, clears the sequencer and output valid only
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Midpoint line rasterizer emitting one pixel per step with optional sides.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpr_pkg::line_in_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpr_pkg::pixel_out_t out_data_o
);

  lpr_pkg::lpr_cmd_t    cmd;
  lpr_pkg::lpr_status_t status;

  lpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lpr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_busy_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("segment transfer did not start drawing");

  a_idle_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && status.last |=> !in_stall_o)
    else $error("not idle after last pixel");

  a_thin_sides_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.sides_valid |->
      out_data_o.plus_side_x == 0 && out_data_o.plus_side_y == 0 &&
      out_data_o.minus_side_x == 0 && out_data_o.minus_side_y == 0)
    else $error("thin line carries side pixels");
`endif

endmodule
